// ===== hdl/chip8_interpreter_core_assert.svh =====
// Assertion macros used by the checker of the CHIP-8 core.
`ifndef CHIP8_INTERPRETER_CORE_ASSERT_SVH
`define CHIP8_INTERPRETER_CORE_ASSERT_SVH

// Next-cycle implication, masked while reset is held.
`define C8IC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define C8IC_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/c8ic_pkg.sv =====
// Shared types, constants and tables of the CHIP-8 interpreter core.
package c8ic_pkg;

    localparam int MEM_BYTES    = 4096;
    localparam int ADDR_W       = 12;
    localparam int SCREEN_COLS  = 64;
    localparam int SCREEN_ROWS  = 32;
    localparam int ROW_W        = 5;
    localparam int STACK_LEVELS = 16;
    localparam int SP_W         = 4;
    localparam int NUM_REGS     = 16;
    localparam int FONT_BASE    = 0;
    localparam int FONT_BYTES   = 80;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 96;
    localparam logic [ADDR_W-1:0] PC_RESET = 12'd512;

    localparam logic [1:0] FUNC_POKE = 2'd0;
    localparam logic [1:0] FUNC_EXEC = 2'd1;
    localparam logic [1:0] FUNC_ROW  = 2'd2;

    // Top nibble of the instruction word
    localparam logic [3:0] OPC_SYS     = 4'h0;
    localparam logic [3:0] OPC_JUMP    = 4'h1;
    localparam logic [3:0] OPC_CALL    = 4'h2;
    localparam logic [3:0] OPC_SEQ_K   = 4'h3;
    localparam logic [3:0] OPC_SNE_K   = 4'h4;
    localparam logic [3:0] OPC_SEQ_R   = 4'h5;
    localparam logic [3:0] OPC_LOAD_K  = 4'h6;
    localparam logic [3:0] OPC_ADD_K   = 4'h7;
    localparam logic [3:0] OPC_ALU     = 4'h8;
    localparam logic [3:0] OPC_SNE_R   = 4'h9;
    localparam logic [3:0] OPC_LOAD_I  = 4'hA;
    localparam logic [3:0] OPC_JUMP_V0 = 4'hB;
    localparam logic [3:0] OPC_RAND    = 4'hC;
    localparam logic [3:0] OPC_DRAW    = 4'hD;
    localparam logic [3:0] OPC_KEY     = 4'hE;
    localparam logic [3:0] OPC_MISC    = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KK_SKP      = 8'h9E;
    localparam logic [7:0] KK_SKNP     = 8'hA1;
    localparam logic [7:0] KK_GET_DT   = 8'h07;
    localparam logic [7:0] KK_WAIT_KEY = 8'h0A;
    localparam logic [7:0] KK_SET_DT   = 8'h15;
    localparam logic [7:0] KK_SET_ST   = 8'h18;
    localparam logic [7:0] KK_ADD_I    = 8'h1E;
    localparam logic [7:0] KK_FONT     = 8'h29;
    localparam logic [7:0] KK_BCD      = 8'h33;
    localparam logic [7:0] KK_STORE    = 8'h55;
    localparam logic [7:0] KK_FILL     = 8'h65;

    localparam logic [7:0] HEX_FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_POKE,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_DECODE,
        ST_READ_X,
        ST_READ_Y,
        ST_EXEC,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_BCD,
        ST_STORE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_TIMER,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MEM_PC, MEM_PC1, MEM_INDEX, MEM_INPUT, MEM_SWEEP
    } mem_sel_t;

    typedef enum logic [1:0] {
        SRC_INPUT, SRC_FONT, SRC_BCD, SRC_REG
    } wsrc_t;

    typedef enum logic [1:0] {
        RSEL_X, RSEL_Y, RSEL_CNT
    } rsel_t;

    typedef enum logic [2:0] {
        LOOP_NONE, LOOP_DRAW, LOOP_BCD, LOOP_STORE, LOOP_FILL
    } loop_t;

    typedef struct packed {
        logic     accept;
        mem_sel_t mem_sel;
        logic     mem_we;
        wsrc_t    wsrc;
        rsel_t    rsel;
        logic     op_hi_ld;
        logic     op_lo_ld;
        logic     vx_ld;
        logic     vy_ld;
        logic     exec;
        logic     draw_step;
        logic     fill_step;
        logic     cnt_inc;
        logic     sweep_inc;
        logic     timer_step;
        logic     out_ld;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        loop_t      loop_kind;
        logic       cnt_last;
        logic       sweep_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== hdl/c8ic_ram.sv =====
// 4 KiB single-port program memory with registered read data.
module c8ic_ram (
    input  logic                          aclk,
    input  logic [c8ic_pkg::ADDR_W-1:0]   addr,
    input  logic                          we,
    input  logic [7:0]                    wdata,
    output logic [7:0]                    rdata
);

    logic [7:0] mem [c8ic_pkg::MEM_BYTES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/c8ic_datapath.sv =====
// Datapath of the CHIP-8 core: registers, stack, timers, screen, memory port, result.
module c8ic_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  c8ic_pkg::cmd_t                    cmd,
    output c8ic_pkg::sts_t                    sts,
    input  logic [c8ic_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              cfg_we,
    input  logic [c8ic_pkg::ADDR_W-1:0]       cfg_wdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [c8ic_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int AW = c8ic_pkg::ADDR_W;

    // latched item
    logic [1:0]    func_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    data_reg;
    logic [4:0]    key_reg;
    logic [7:0]    rnd_reg;

    logic [15:0]   op_reg;
    logic [7:0]    vx_reg, vy_reg;
    logic [7:0]    v_reg [c8ic_pkg::NUM_REGS];
    logic [15:0]   i_reg;
    logic [AW-1:0] pc_reg;
    logic [AW-1:0] stack_reg [c8ic_pkg::STACK_LEVELS];
    logic [c8ic_pkg::SP_W-1:0] sp_reg;
    logic [7:0]    delay_reg, sound_reg;
    logic [c8ic_pkg::SCREEN_COLS-1:0] screen_reg [c8ic_pkg::SCREEN_ROWS];
    logic [3:0]    cnt_reg;
    logic [AW-1:0] sweep_reg;
    logic          wait_reg, pulse_reg;
    logic          m_valid_reg;
    logic [c8ic_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [3:0] opc, fx, fy, fn;
    logic [7:0] kk;
    logic [AW-1:0] nnn;

    assign opc = op_reg[15:12];
    assign fx  = op_reg[11:8];
    assign fy  = op_reg[7:4];
    assign fn  = op_reg[3:0];
    assign kk  = op_reg[7:0];
    assign nnn = op_reg[11:0];

    // register file read port
    logic [3:0] ridx;
    logic [7:0] rf_rdata;

    always_comb begin
        case (cmd.rsel)
            c8ic_pkg::RSEL_X:   ridx = fx;
            c8ic_pkg::RSEL_Y:   ridx = (opc == c8ic_pkg::OPC_JUMP_V0) ? 4'd0 : fy;
            default:            ridx = cnt_reg;
        endcase
    end
    assign rf_rdata = v_reg[ridx];

    // BCD digits of Vx
    logic [1:0]  bcd_h;
    logic [7:0]  bcd_rem;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;
    logic [7:0]  bcd_digit;

    always_comb begin
        if (vx_reg >= 8'd200)      bcd_h = 2'd2;
        else if (vx_reg >= 8'd100) bcd_h = 2'd1;
        else                       bcd_h = 2'd0;
        bcd_rem  = vx_reg - 8'(bcd_h * 7'd100);
        bcd_prod = 15'(bcd_rem[6:0] * 8'd205);
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_rem - 8'(bcd_t * 4'd10);
        case (cnt_reg)
            4'd0:    bcd_digit = {6'd0, bcd_h};
            4'd1:    bcd_digit = {4'd0, bcd_t};
            default: bcd_digit = bcd_o;
        endcase
    end

    // memory port
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_q, font_b;
    logic [AW-1:0] font_off;

    assign font_off = sweep_reg - AW'(c8ic_pkg::FONT_BASE);
    assign font_b   = (font_off < AW'(c8ic_pkg::FONT_BYTES)) ?
                      c8ic_pkg::HEX_FONT[font_off[6:0]] : 8'd0;

    always_comb begin
        case (cmd.mem_sel)
            c8ic_pkg::MEM_PC:    mem_addr = pc_reg;
            c8ic_pkg::MEM_PC1:   mem_addr = pc_reg + AW'(1);
            c8ic_pkg::MEM_INDEX: mem_addr = i_reg[AW-1:0] + AW'(cnt_reg);
            c8ic_pkg::MEM_INPUT: mem_addr = addr_reg;
            default:             mem_addr = sweep_reg;
        endcase
        case (cmd.wsrc)
            c8ic_pkg::SRC_INPUT: mem_wdata = data_reg;
            c8ic_pkg::SRC_FONT:  mem_wdata = font_b;
            c8ic_pkg::SRC_BCD:   mem_wdata = bcd_digit;
            default:             mem_wdata = rf_rdata;
        endcase
    end

    c8ic_ram u_ram (
        .aclk  (aclk),
        .addr  (mem_addr),
        .we    (cmd.mem_we),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    // instruction execute
    logic          has_key;
    logic          ex_skip;
    logic          ex_rf_we, ex_vf_we;
    logic [7:0]    ex_rf, ex_vf;
    logic [AW-1:0] ex_pc;
    logic          ex_pc_we;
    logic          ex_push, ex_pop, ex_cls, ex_wait;
    logic          ex_i_we, ex_dt_we, ex_st_we;
    logic [15:0]   ex_i;
    logic          fl;
    logic [7:0]    ax, ay;
    logic [8:0]    sum9;

    assign has_key = !key_reg[4];

    always_comb begin
        ex_skip  = 1'b0;
        ex_rf_we = 1'b0;
        ex_rf    = 8'd0;
        ex_vf_we = 1'b0;
        ex_vf    = 8'd0;
        ex_pc_we = 1'b0;
        ex_pc    = pc_reg;
        ex_push  = 1'b0;
        ex_pop   = 1'b0;
        ex_cls   = 1'b0;
        ex_wait  = 1'b0;
        ex_i_we  = 1'b0;
        ex_i     = i_reg;
        ex_dt_we = 1'b0;
        ex_st_we = 1'b0;
        fl       = 1'b0;
        sum9     = {1'b0, vx_reg} + {1'b0, vy_reg};
        ax       = vx_reg;
        ay       = vy_reg;
        case (opc)
            c8ic_pkg::OPC_SYS: begin
                if (op_reg == c8ic_pkg::OP_CLS) begin
                    ex_cls = 1'b1;
                end else if (op_reg == c8ic_pkg::OP_RET) begin
                    ex_pop   = 1'b1;
                    ex_pc_we = 1'b1;
                    ex_pc    = stack_reg[sp_reg - c8ic_pkg::SP_W'(1)];
                end
            end
            c8ic_pkg::OPC_JUMP: begin
                ex_pc_we = 1'b1;
                ex_pc    = nnn;
            end
            c8ic_pkg::OPC_CALL: begin
                ex_push  = 1'b1;
                ex_pc_we = 1'b1;
                ex_pc    = nnn;
            end
            c8ic_pkg::OPC_SEQ_K:  ex_skip = (vx_reg == kk);
            c8ic_pkg::OPC_SNE_K:  ex_skip = (vx_reg != kk);
            c8ic_pkg::OPC_SEQ_R:  ex_skip = (fn == 4'd0) && (vx_reg == vy_reg);
            c8ic_pkg::OPC_SNE_R:  ex_skip = (fn == 4'd0) && (vx_reg != vy_reg);
            c8ic_pkg::OPC_LOAD_K: begin
                ex_rf_we = 1'b1;
                ex_rf    = kk;
            end
            c8ic_pkg::OPC_ADD_K: begin
                ex_rf_we = 1'b1;
                ex_rf    = vx_reg + kk;
            end
            c8ic_pkg::OPC_ALU: begin
                // flag goes to VF first; subtract and shift operands naming VF then see the flag
                case (fn)
                    c8ic_pkg::ALU_SUB: fl = vx_reg > vy_reg;
                    c8ic_pkg::ALU_SHR: fl = vx_reg[0];
                    c8ic_pkg::ALU_SBN: fl = vy_reg > vx_reg;
                    c8ic_pkg::ALU_SHL: fl = vx_reg[7];
                    default:           fl = sum9[8];
                endcase
                if (fx == 4'hF) ax = {7'd0, fl};
                if (fy == 4'hF) ay = {7'd0, fl};
                ex_rf_we = 1'b1;
                ex_vf    = {7'd0, fl};
                case (fn)
                    c8ic_pkg::ALU_MOV: ex_rf = vy_reg;
                    c8ic_pkg::ALU_OR:  ex_rf = vx_reg | vy_reg;
                    c8ic_pkg::ALU_AND: ex_rf = vx_reg & vy_reg;
                    c8ic_pkg::ALU_XOR: ex_rf = vx_reg ^ vy_reg;
                    c8ic_pkg::ALU_ADD: begin
                        ex_vf_we = 1'b1;
                        ex_rf    = sum9[7:0];
                    end
                    c8ic_pkg::ALU_SUB: begin
                        ex_vf_we = 1'b1;
                        ex_rf    = ax - ay;
                    end
                    c8ic_pkg::ALU_SHR: begin
                        ex_vf_we = 1'b1;
                        ex_rf    = ax >> 1;
                    end
                    c8ic_pkg::ALU_SBN: begin
                        ex_vf_we = 1'b1;
                        ex_rf    = ay - ax;
                    end
                    c8ic_pkg::ALU_SHL: begin
                        ex_vf_we = 1'b1;
                        ex_rf    = ax << 1;
                    end
                    default: ex_rf_we = 1'b0;
                endcase
            end
            c8ic_pkg::OPC_LOAD_I: begin
                ex_i_we = 1'b1;
                ex_i    = {4'd0, nnn};
            end
            c8ic_pkg::OPC_JUMP_V0: begin
                ex_pc_we = 1'b1;
                ex_pc    = AW'(vy_reg) + nnn;
            end
            c8ic_pkg::OPC_RAND: begin
                ex_rf_we = 1'b1;
                ex_rf    = rnd_reg & kk;
            end
            c8ic_pkg::OPC_DRAW: begin
                ex_vf_we = 1'b1;
                ex_vf    = 8'd0;
            end
            c8ic_pkg::OPC_KEY: begin
                if (kk == c8ic_pkg::KK_SKP)
                    ex_skip = has_key && ({4'd0, key_reg[3:0]} == vx_reg);
                else if (kk == c8ic_pkg::KK_SKNP)
                    ex_skip = !(has_key && ({4'd0, key_reg[3:0]} == vx_reg));
            end
            default: begin
                case (kk)
                    c8ic_pkg::KK_GET_DT: begin
                        ex_rf_we = 1'b1;
                        ex_rf    = delay_reg;
                    end
                    c8ic_pkg::KK_WAIT_KEY: begin
                        if (has_key) begin
                            ex_rf_we = 1'b1;
                            ex_rf    = {4'd0, key_reg[3:0]};
                        end else begin
                            ex_wait  = 1'b1;
                            ex_pc_we = 1'b1;
                            ex_pc    = pc_reg - AW'(2);
                        end
                    end
                    c8ic_pkg::KK_SET_DT: ex_dt_we = 1'b1;
                    c8ic_pkg::KK_SET_ST: ex_st_we = 1'b1;
                    c8ic_pkg::KK_ADD_I: begin
                        ex_i_we = 1'b1;
                        ex_i    = i_reg + {8'd0, vx_reg};
                    end
                    c8ic_pkg::KK_FONT: begin
                        ex_i_we = 1'b1;
                        ex_i    = 16'(c8ic_pkg::FONT_BASE) + {6'd0, vx_reg, 2'b00}
                                  + {8'd0, vx_reg};
                    end
                    default: ;
                endcase
            end
        endcase
        if (ex_skip) begin
            ex_pc_we = 1'b1;
            ex_pc    = pc_reg + AW'(2);
        end
    end

    // loop kind and last-pass detect
    localparam int ROW_W_L = c8ic_pkg::ROW_W;
    logic [5:0] draw_row6;
    logic [ROW_W_L-1:0] draw_row;
    logic [c8ic_pkg::SCREEN_COLS-1:0] draw_mask, draw_old;
    logic [c8ic_pkg::SCREEN_COLS+7:0] draw_wide;

    assign draw_row6 = {1'b0, vy_reg[4:0]} + {2'b00, cnt_reg};
    assign draw_row  = draw_row6[ROW_W_L-1:0];
    assign draw_wide = {mem_q, 64'd0} >> vx_reg[5:0];
    assign draw_mask = draw_wide[71:8];
    assign draw_old  = screen_reg[draw_row];

    always_comb begin
        sts.func       = func_reg;
        sts.sweep_last = (sweep_reg == {AW{1'b1}});
        sts.out_free   = !m_valid_reg || m_tready;
        sts.loop_kind  = c8ic_pkg::LOOP_NONE;
        if (opc == c8ic_pkg::OPC_DRAW && fn != 4'd0)
            sts.loop_kind = c8ic_pkg::LOOP_DRAW;
        else if (opc == c8ic_pkg::OPC_MISC && kk == c8ic_pkg::KK_BCD)
            sts.loop_kind = c8ic_pkg::LOOP_BCD;
        else if (opc == c8ic_pkg::OPC_MISC && kk == c8ic_pkg::KK_STORE)
            sts.loop_kind = c8ic_pkg::LOOP_STORE;
        else if (opc == c8ic_pkg::OPC_MISC && kk == c8ic_pkg::KK_FILL)
            sts.loop_kind = c8ic_pkg::LOOP_FILL;
        case (sts.loop_kind)
            c8ic_pkg::LOOP_DRAW: sts.cnt_last = (cnt_reg == fn - 4'd1)
                                                || (draw_row6 == 6'd31);
            c8ic_pkg::LOOP_BCD:  sts.cnt_last = (cnt_reg == 4'd2);
            c8ic_pkg::LOOP_STORE,
            c8ic_pkg::LOOP_FILL: sts.cnt_last = (cnt_reg == fx);
            default:             sts.cnt_last = 1'b1;
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_tdata[1:0];
            addr_reg <= s_tdata[13:2];
            data_reg <= s_tdata[21:14];
            key_reg  <= s_tdata[26:22];
            rnd_reg  <= s_tdata[34:27];
        end
        if (cmd.op_hi_ld) op_reg[15:8] <= mem_q;
        if (cmd.op_lo_ld) op_reg[7:0]  <= mem_q;
        if (cmd.vx_ld)    vx_reg <= rf_rdata;
        if (cmd.vy_ld)    vy_reg <= rf_rdata;
        if (cmd.exec && ex_push) stack_reg[sp_reg] <= pc_reg;
        if (cmd.exec)     cnt_reg <= 4'd0;
        else if (cmd.cnt_inc) cnt_reg <= cnt_reg + 4'd1;
        if (cmd.exec)     wait_reg <= ex_wait;
        if (cmd.timer_step) pulse_reg <= (sound_reg == 8'd1);
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < c8ic_pkg::NUM_REGS; r++) v_reg[r] <= 8'd0;
            for (int r = 0; r < c8ic_pkg::SCREEN_ROWS; r++) screen_reg[r] <= '0;
            i_reg     <= 16'd0;
            pc_reg    <= c8ic_pkg::PC_RESET;
            sp_reg    <= '0;
            delay_reg <= 8'd0;
            sound_reg <= 8'd0;
            sweep_reg <= '0;
        end else begin
            if (cmd.sweep_inc) sweep_reg <= sweep_reg + AW'(1);
            if (cmd.op_lo_ld) pc_reg <= pc_reg + AW'(2);
            if (cmd.exec) begin
                if (ex_pc_we) pc_reg <= ex_pc;
                if (ex_push)  sp_reg <= sp_reg + c8ic_pkg::SP_W'(1);
                if (ex_pop)   sp_reg <= sp_reg - c8ic_pkg::SP_W'(1);
                if (ex_i_we)  i_reg <= ex_i;
                if (ex_dt_we) delay_reg <= vx_reg;
                if (ex_st_we) sound_reg <= vx_reg;
                if (ex_cls)
                    for (int r = 0; r < c8ic_pkg::SCREEN_ROWS; r++) screen_reg[r] <= '0;
                if (ex_vf_we) v_reg[15] <= ex_vf;
                if (ex_rf_we) v_reg[fx] <= ex_rf;
            end
            if (cmd.fill_step) v_reg[cnt_reg] <= mem_q;
            if (cmd.draw_step) begin
                screen_reg[draw_row] <= draw_old ^ draw_mask;
                if ((draw_old & draw_mask) != '0) v_reg[15] <= 8'd1;
            end
            if (cmd.timer_step) begin
                if (delay_reg != 8'd0) delay_reg <= delay_reg - 8'd1;
                if (sound_reg != 8'd0) sound_reg <= sound_reg - 8'd1;
            end
            if (cfg_we) pc_reg <= cfg_wdata;
        end
    end

    // result register
    logic is_exec, is_row;
    assign is_exec = (func_reg == c8ic_pkg::FUNC_EXEC);
    assign is_row  = (func_reg == c8ic_pkg::FUNC_ROW)
                     && (addr_reg < AW'(c8ic_pkg::SCREEN_ROWS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            m_data_reg <= {2'b00,
                           is_exec & wait_reg,
                           is_exec & pulse_reg,
                           is_row ? screen_reg[addr_reg[ROW_W_L-1:0]] : 64'd0,
                           is_exec ? op_reg : 16'd0,
                           pc_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== hdl/c8ic_ctrl.sv =====
// Sequencer of the CHIP-8 core: walks each transaction through the datapath.
module c8ic_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  c8ic_pkg::sts_t  sts,
    output c8ic_pkg::cmd_t  cmd
);

    c8ic_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= c8ic_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            c8ic_pkg::ST_CLEAR:    if (sts.sweep_last) state_next = c8ic_pkg::ST_IDLE;
            c8ic_pkg::ST_IDLE:     if (s_tvalid) state_next = c8ic_pkg::ST_DISPATCH;
            c8ic_pkg::ST_DISPATCH: begin
                if (sts.func == c8ic_pkg::FUNC_POKE)
                    state_next = c8ic_pkg::ST_POKE;
                else if (sts.func == c8ic_pkg::FUNC_EXEC)
                    state_next = c8ic_pkg::ST_FETCH_HI;
                else
                    state_next = c8ic_pkg::ST_DONE;
            end
            c8ic_pkg::ST_POKE:     state_next = c8ic_pkg::ST_DONE;
            c8ic_pkg::ST_FETCH_HI: state_next = c8ic_pkg::ST_FETCH_LO;
            c8ic_pkg::ST_FETCH_LO: state_next = c8ic_pkg::ST_DECODE;
            c8ic_pkg::ST_DECODE:   state_next = c8ic_pkg::ST_READ_X;
            c8ic_pkg::ST_READ_X:   state_next = c8ic_pkg::ST_READ_Y;
            c8ic_pkg::ST_READ_Y:   state_next = c8ic_pkg::ST_EXEC;
            c8ic_pkg::ST_EXEC: begin
                unique case (sts.loop_kind)
                    c8ic_pkg::LOOP_DRAW:  state_next = c8ic_pkg::ST_DRAW_RD;
                    c8ic_pkg::LOOP_BCD:   state_next = c8ic_pkg::ST_BCD;
                    c8ic_pkg::LOOP_STORE: state_next = c8ic_pkg::ST_STORE;
                    c8ic_pkg::LOOP_FILL:  state_next = c8ic_pkg::ST_FILL_RD;
                    default:              state_next = c8ic_pkg::ST_TIMER;
                endcase
            end
            c8ic_pkg::ST_DRAW_RD:  state_next = c8ic_pkg::ST_DRAW_WR;
            c8ic_pkg::ST_DRAW_WR:
                state_next = sts.cnt_last ? c8ic_pkg::ST_TIMER : c8ic_pkg::ST_DRAW_RD;
            c8ic_pkg::ST_BCD:
                if (sts.cnt_last) state_next = c8ic_pkg::ST_TIMER;
            c8ic_pkg::ST_STORE:
                if (sts.cnt_last) state_next = c8ic_pkg::ST_TIMER;
            c8ic_pkg::ST_FILL_RD:  state_next = c8ic_pkg::ST_FILL_WR;
            c8ic_pkg::ST_FILL_WR:
                state_next = sts.cnt_last ? c8ic_pkg::ST_TIMER : c8ic_pkg::ST_FILL_RD;
            c8ic_pkg::ST_TIMER:    state_next = c8ic_pkg::ST_DONE;
            c8ic_pkg::ST_DONE:     if (sts.out_free) state_next = c8ic_pkg::ST_IDLE;
            default:               state_next = c8ic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            c8ic_pkg::ST_CLEAR: begin
                cmd.mem_sel   = c8ic_pkg::MEM_SWEEP;
                cmd.wsrc      = c8ic_pkg::SRC_FONT;
                cmd.mem_we    = 1'b1;
                cmd.sweep_inc = 1'b1;
            end
            c8ic_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            c8ic_pkg::ST_DISPATCH: ;
            c8ic_pkg::ST_POKE: begin
                cmd.mem_sel = c8ic_pkg::MEM_INPUT;
                cmd.wsrc    = c8ic_pkg::SRC_INPUT;
                cmd.mem_we  = 1'b1;
            end
            c8ic_pkg::ST_FETCH_HI: cmd.mem_sel = c8ic_pkg::MEM_PC;
            c8ic_pkg::ST_FETCH_LO: begin
                cmd.mem_sel  = c8ic_pkg::MEM_PC1;
                cmd.op_hi_ld = 1'b1;
            end
            c8ic_pkg::ST_DECODE:   cmd.op_lo_ld = 1'b1;
            c8ic_pkg::ST_READ_X: begin
                cmd.rsel  = c8ic_pkg::RSEL_X;
                cmd.vx_ld = 1'b1;
            end
            c8ic_pkg::ST_READ_Y: begin
                cmd.rsel  = c8ic_pkg::RSEL_Y;
                cmd.vy_ld = 1'b1;
            end
            c8ic_pkg::ST_EXEC:     cmd.exec = 1'b1;
            c8ic_pkg::ST_DRAW_RD:  cmd.mem_sel = c8ic_pkg::MEM_INDEX;
            c8ic_pkg::ST_DRAW_WR: begin
                cmd.draw_step = 1'b1;
                cmd.cnt_inc   = 1'b1;
            end
            c8ic_pkg::ST_BCD: begin
                cmd.mem_sel = c8ic_pkg::MEM_INDEX;
                cmd.wsrc    = c8ic_pkg::SRC_BCD;
                cmd.mem_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            c8ic_pkg::ST_STORE: begin
                cmd.mem_sel = c8ic_pkg::MEM_INDEX;
                cmd.wsrc    = c8ic_pkg::SRC_REG;
                cmd.rsel    = c8ic_pkg::RSEL_CNT;
                cmd.mem_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            c8ic_pkg::ST_FILL_RD:  cmd.mem_sel = c8ic_pkg::MEM_INDEX;
            c8ic_pkg::ST_FILL_WR: begin
                cmd.fill_step = 1'b1;
                cmd.cnt_inc   = 1'b1;
            end
            c8ic_pkg::ST_TIMER:    cmd.timer_step = 1'b1;
            c8ic_pkg::ST_DONE:     cmd.out_ld = sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hdl/chip8_interpreter_core.sv =====
// Top level of the CHIP-8 interpreter core: stream ports, sequencer and datapath.
//
//  channel  | direction | tdata fields (lowest bit up)
//  ---------+-----------+---------------------------------------------------------
//  s_       | in        | func[1:0] address[13:2] data[21:14] key[26:22] rnd[34:27]
//  m_       | out       | pc[11:0] opcode[27:12] row[91:28] pulse[92] waiting[93]
//  cfg_     | in        | program_start[11:0], write on cfg_we
//
// The sequencer steps each transaction through its states, one per memory access,
// register read or datapath step, as there is a single memory port; sprites loop a
// read and a write state per row, FX33 and FX55 a write state per byte, FX65 a read
// and a write state per register. After reset a clearing pass writes the font and
// zeros over all 4096 bytes with s_tready low; cfg writes are taken during it.
// One transaction is in flight at a time; a new one is accepted while the
// previous result still waits in the output register, and a stalled m_ side
// holds the finished transaction in its last state until m_tready.
module chip8_interpreter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func, address, data, key, random_byte
    input  logic [c8ic_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // program_counter, fetched_opcode, row_bits, sound_pulse, waiting_key
    output logic [c8ic_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [c8ic_pkg::ADDR_W-1:0]       cfg_wdata
);

    c8ic_pkg::cmd_t cmd;
    c8ic_pkg::sts_t sts;

    // sequencer: one state per memory access, register read or datapath step
    c8ic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: memory, register file, screen, timers and result register
    c8ic_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hdl/c8ic_checker.sv =====
// Port-level checker of the CHIP-8 core and its bind to the top level.
`include "chip8_interpreter_core_assert.svh"

module c8ic_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [c8ic_pkg::M_TDATA_W-1:0]    m_tdata
);

    `C8IC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `C8IC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed")
    `C8IC_ASSERT_NEXT(a_one_inflight, s_tvalid && s_tready, !s_tready, "second accept")
    `C8IC_ASSERT_NEXT_ANY(a_reset_busy, !aresetn, !s_tready && !m_tvalid, "ready after reset")

endmodule

bind chip8_interpreter_core c8ic_checker u_c8ic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Stream-level testbench for the CHIP-8 interpreter core with a built-in predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c8ic_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // idle cycles; covers the clear pass after reset
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 300;

    // lowest field last, so pc sits in the low bits as on m_tdata
    typedef struct packed {
        logic        waiting;
        logic        pulse;
        logic [63:0] row;
        logic [15:0] opcode;
        logic [11:0] pc;
    } core_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // func, address, data, key, random_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // pc, opcode, row, pulse, waiting
    logic                 cfg_we = 1'b0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;

    always #4 aclk = ~aclk;

    chip8_interpreter_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // ---- predictor state: a shadow copy of the core ----
    bit [7:0]  core_mem [MEM_BYTES];
    bit [7:0]  core_v [16];
    bit [15:0] core_i;
    bit [11:0] core_pc;
    bit [11:0] core_stack [STACK_LEVELS];
    bit        stack_valid [STACK_LEVELS];  // return slots written by a call
    bit [3:0]  core_sp;
    bit [7:0]  delay_t, sound_t;
    bit [63:0] screen_rows [SCREEN_ROWS];

    core_result_t pending_results [$];
    int  mismatches = 0;
    int  tx_idle_pct = 0;    // chance per cycle that the sender idles
    int  rx_stall_pct = 0;   // chance per cycle that the receiver stalls
    bit  rx_hold = 0;        // long receiver hold-off
    int  quiet_cycles = 0;

    // Runs one transaction on the shadow core and returns the result it yields.
    function automatic core_result_t next_result(bit [1:0] f, bit [11:0] a, bit [7:0] d,
                                                 bit [4:0] k, bit [7:0] rnd);
        core_result_t r;
        bit [15:0] op;
        bit [3:0]  x, y, n;
        bit [7:0]  kk, vx;
        bit [8:0]  sum;
        bit [63:0] bits, mask;
        int        xs, ys;
        bit        has_key, skip;
        r = '0;
        case (f)
            FUNC_POKE: core_mem[a] = d;
            FUNC_ROW:  if (a < SCREEN_ROWS) r.row = screen_rows[a[4:0]];
            FUNC_EXEC: begin
                op = {core_mem[core_pc], core_mem[core_pc + 12'd1]};
                r.opcode = op;
                core_pc += 12'd2;
                x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
                vx = core_v[x];
                has_key = (k <= 15);
                skip = 0;
                case (op[15:12])
                    OPC_SYS: begin
                        if (op == OP_CLS) begin
                            foreach (screen_rows[j]) screen_rows[j] = '0;
                        end else if (op == OP_RET) begin
                            core_sp -= 4'd1;
                            core_pc = core_stack[core_sp];
                        end
                    end
                    OPC_JUMP: core_pc = op[11:0];
                    OPC_CALL: begin
                        core_stack[core_sp] = core_pc;
                        stack_valid[core_sp] = 1;
                        core_sp += 4'd1;
                        core_pc = op[11:0];
                    end
                    OPC_SEQ_K:   skip = (vx == kk);
                    OPC_SNE_K:   skip = (vx != kk);
                    OPC_SEQ_R:   skip = (n == 0) && (vx == core_v[y]);
                    OPC_LOAD_K:  core_v[x] = kk;
                    OPC_ADD_K:   core_v[x] = vx + kk;
                    OPC_SNE_R:   skip = (n == 0) && (vx != core_v[y]);
                    OPC_LOAD_I:  core_i = {4'h0, op[11:0]};
                    OPC_JUMP_V0: core_pc = core_v[0] + op[11:0];
                    OPC_RAND:    core_v[x] = rnd & kk;
                    OPC_ALU: begin
                        // flag written first; subtracts and shifts then take operands from the updated file
                        case (n)
                            ALU_MOV: core_v[x] = core_v[y];
                            ALU_OR:  core_v[x] |= core_v[y];
                            ALU_AND: core_v[x] &= core_v[y];
                            ALU_XOR: core_v[x] ^= core_v[y];
                            ALU_ADD: begin
                                sum = core_v[x] + core_v[y];
                                core_v[15] = {7'd0, sum[8]};
                                core_v[x] = sum[7:0];
                            end
                            ALU_SUB: begin
                                core_v[15] = {7'd0, core_v[x] > core_v[y]};
                                core_v[x] = core_v[x] - core_v[y];
                            end
                            ALU_SHR: begin
                                core_v[15] = {7'd0, core_v[x][0]};
                                core_v[x] = core_v[x] >> 1;
                            end
                            ALU_SBN: begin
                                core_v[15] = {7'd0, core_v[y] > core_v[x]};
                                core_v[x] = core_v[y] - core_v[x];
                            end
                            ALU_SHL: begin
                                core_v[15] = {7'd0, core_v[x][7]};
                                core_v[x] = core_v[x] << 1;
                            end
                            default: ;
                        endcase
                    end
                    OPC_DRAW: begin
                        xs = vx % SCREEN_COLS;
                        ys = core_v[y] % SCREEN_ROWS;
                        core_v[15] = 0;
                        for (int row = 0; row < n; row++) begin
                            if (ys + row >= SCREEN_ROWS) break;
                            bits = {56'd0, core_mem[12'(core_i + row)]};
                            mask = (xs <= 56) ? bits << (56 - xs) : bits >> (xs - 56);
                            if ((screen_rows[ys + row] & mask) != 0) core_v[15] = 1;
                            screen_rows[ys + row] ^= mask;
                        end
                    end
                    OPC_KEY: begin
                        if (kk == KK_SKP)       skip = has_key && (k == vx);
                        else if (kk == KK_SKNP) skip = !(has_key && (k == vx));
                    end
                    OPC_MISC: begin
                        case (kk)
                            KK_GET_DT: core_v[x] = delay_t;
                            KK_WAIT_KEY: begin
                                if (has_key) core_v[x] = {3'd0, k};
                                else begin
                                    core_pc -= 12'd2;
                                    r.waiting = 1;
                                end
                            end
                            KK_SET_DT: delay_t = vx;
                            KK_SET_ST: sound_t = vx;
                            KK_ADD_I:  core_i += vx;
                            KK_FONT:   core_i = FONT_BASE + 16'd5 * vx;
                            KK_BCD: begin
                                core_mem[12'(core_i)]     = vx / 100;
                                core_mem[12'(core_i + 1)] = (vx / 10) % 10;
                                core_mem[12'(core_i + 2)] = vx % 10;
                            end
                            KK_STORE: for (int j = 0; j <= x; j++)
                                core_mem[12'(core_i + j)] = core_v[j];
                            KK_FILL: for (int j = 0; j <= x; j++)
                                core_v[j] = core_mem[12'(core_i + j)];
                            default: ;
                        endcase
                    end
                endcase
                if (skip) core_pc += 12'd2;
                if (delay_t != 0) delay_t--;
                if (sound_t != 0) begin
                    if (sound_t == 1) r.pulse = 1;
                    sound_t--;
                end
            end
            default: ;
        endcase
        r.pc = core_pc;
        return r;
    endfunction

    // Offers one transaction, waits for acceptance, then idles at random.
    task automatic send_item(bit [1:0] f, bit [11:0] a, bit [7:0] d = 0, bit [4:0] k = 16,
                             bit [7:0] rnd = 0);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, rnd, k, d, a, f};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(next_result(f, a, d, k, rnd));
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Executes the word at the current pc, patching a return from an empty slot into CLS.
    task automatic step_cpu(bit [4:0] k, bit [7:0] rnd);
        if ({core_mem[core_pc], core_mem[core_pc + 12'd1]} == OP_RET &&
            !stack_valid[core_sp - 4'd1])
            send_item(FUNC_POKE, core_pc + 12'd1, OP_CLS[7:0]);
        send_item(FUNC_EXEC, 0, 0, k, rnd);
    endtask

    // Places an instruction at the current pc and executes it.
    task automatic run_word(bit [15:0] w, bit [4:0] k = 16, bit [7:0] rnd = 0);
        send_item(FUNC_POKE, core_pc, w[15:8]);
        send_item(FUNC_POKE, core_pc + 12'd1, w[7:0]);
        step_cpu(k, rnd);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_program_start(bit [11:0] addr);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge aclk);
        cfg_we <= 1'b0;
        core_pc = addr;
    endtask

    function automatic bit [15:0] random_word();
        bit [7:0] misc_kk [11] = '{KK_GET_DT, KK_WAIT_KEY, KK_SET_DT, KK_SET_ST, KK_ADD_I,
                                   KK_FONT, KK_BCD, KK_STORE, KK_FILL, KK_GET_DT, KK_SET_ST};
        bit [3:0]  alu_n [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB,
                                 ALU_SHR, ALU_SBN, ALU_SHL};
        bit [15:0] w;
        w = 16'($urandom);
        case (w[15:12])
            OPC_SYS: case ($urandom_range(3))
                0: w = OP_CLS;
                1, 2: w = OP_RET;
                default: ;
            endcase
            OPC_LOAD_K: if ($urandom_range(1)) w[7:0] = 8'($urandom_range(8));
            OPC_SEQ_R, OPC_SNE_R: if ($urandom_range(3) != 0) w[3:0] = 0;
            OPC_ALU: if ($urandom_range(7) != 0) w[3:0] = alu_n[$urandom_range(8)];
            OPC_DRAW: if ($urandom_range(3) == 0) w[3:0] = 4'($urandom_range(2));
            OPC_KEY: case ($urandom_range(2))
                0: w[7:0] = KK_SKP;
                1: w[7:0] = KK_SKNP;
                default: ;
            endcase
            OPC_MISC: if ($urandom_range(7) != 0) w[7:0] = misc_kk[$urandom_range(10)];
            default: ;
        endcase
        return w;
    endfunction

    function automatic bit [4:0] random_key(bit [3:0] x);
        case ($urandom_range(2))
            0: return 5'($urandom_range(16, 31));
            1: return (core_v[x] < 16) ? core_v[x][4:0] : 5'($urandom_range(15));
            default: return 5'($urandom_range(15));
        endcase
    endfunction

    // Mostly well-formed instruction steps, with loads, row reads and noise between.
    task automatic random_traffic(int count);
        bit [15:0] w;
        int        pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                w = random_word();
                run_word(w, random_key(w[11:8]), 8'($urandom));
            end else if (pick < 72)
                send_item(FUNC_ROW, ($urandom_range(7) == 0) ? 12'($urandom)
                                                              : 12'($urandom_range(31)));
            else if (pick < 88)
                send_item(FUNC_POKE, 12'($urandom), 8'($urandom));
            else if (pick < 95)
                step_cpu(5'($urandom), 8'($urandom));
            else
                send_item(2'd3, 12'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
        end
    endtask

    // ---- tests ----
    task automatic test_opcode_corners();
        run_word(16'h60FF);                 // V0 = 255
        run_word(16'h7001);                 // wraps to 0
        run_word(16'h6139);                 // V1 = 57: sprite runs off the right edge
        run_word(16'h621F);                 // V2 = 31: and off the bottom
        run_word(16'hD12F);
        send_item(FUNC_ROW, 12'd31);
        send_item(FUNC_ROW, 12'd32);        // past the last row
        send_item(2'd3, 12'hFFF, 8'hFF, 5'h1F, 8'hFF);
        run_word(16'hE0A1, 5'd16);          // no key: always skips
        run_word(16'hF00A, 5'd31);          // no key: waits in place
        run_word(16'h8FE4);                 // flag register as destination
        run_word(16'hF318);
    endtask

    task automatic test_call_return();
        bit [11:0] target;
        target = core_pc + 12'h100;
        run_word({OPC_CALL, target});
        run_word(OP_RET);
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold = 1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 0;
            end
            random_traffic(30);
        join
    endtask

    task automatic test_random_phases();
        int idle_tx [4] = '{0, 78, 0, 15};
        int idle_rx [4] = '{0, 0, 78, 15};
        bit [11:0] starts [4] = '{12'd0, 12'hFFF, 12'h200, 12'h000};
        for (int p = 0; p < 4; p++) begin
            starts[3] = 12'($urandom);
            set_program_start(starts[p]);
            tx_idle_pct = idle_tx[p];
            rx_stall_pct = idle_rx[p];
            random_traffic(80);
        end
    endtask

    // ---- result checker and watchdog ----
    always @(posedge aclk) begin : check_results
        core_result_t got, want;
        if (m_tvalid && m_tready) begin
            got = m_tdata[93:0];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.pc !== want.pc || got.opcode !== want.opcode ||
                    got.row !== want.row || got.pulse !== want.pulse ||
                    got.waiting !== want.waiting) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch pc %h/%h op %h/%h row %h/%h pulse %b/%b wait %b/%b",
                                 want.pc, got.pc, want.opcode, got.opcode, want.row,
                                 got.row, want.pulse, got.pulse, want.waiting, got.waiting);
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

        if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        core_mem = '{default: 0};
        foreach (HEX_FONT[j]) core_mem[FONT_BASE + j] = HEX_FONT[j];
        core_v = '{default: 0};
        core_stack = '{default: 0};
        stack_valid = '{default: 0};
        screen_rows = '{default: 0};
        core_i = 0; core_sp = 0; delay_t = 0; sound_t = 0;
        core_pc = PC_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_opcode_corners();
        test_call_return();
        test_random_phases();
        test_backpressure();
        set_program_start(12'd512);
        tx_idle_pct = 15;
        rx_stall_pct = 15;
        random_traffic(50);
        drain();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
